// File: hw/rtl/mrw_pkg.sv
`default_nettype none

package mrw_pkg;

  localparam int unsigned HeaderBytes   = 44;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] TypeX2apic       = 8'd9;
  localparam logic [7:0] TypeAddrOverride = 8'd5;

  // result kinds
  localparam logic [1:0] KindRecord = 2'd0;
  localparam logic [1:0] KindGood   = 2'd1;
  localparam logic [1:0] KindBad    = 2'd2;

  // malformed causes
  localparam logic [1:0] CauseShort     = 2'd0;
  localparam logic [1:0] CauseTruncated = 2'd1;
  localparam logic [1:0] CauseLenSmall  = 2'd2;
  localparam logic [1:0] CauseOverrun   = 2'd3;

  localparam logic [2:0] ClassX2apic  = 3'd6;
  localparam logic [2:0] ClassUnknown = 3'd7;

  // one queued event: a first result and, when two_res is set, a
  // well formed verdict that follows it at offset good_off
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rtype;
    logic [7:0]  rlen;
    logic [31:0] roff;
    logic [2:0]  cls;
    logic [1:0]  cause;
    logic [31:0] addr;
    logic        two_res;
    logic [31:0] good_off;
  } mrw_event_t;

  function automatic logic [2:0] type_class(input logic [7:0] t);
    logic [2:0] c;
    if (t <= TypeAddrOverride) begin
      c = t[2:0];
    end else if (t == TypeX2apic) begin
      c = ClassX2apic;
    end else begin
      c = ClassUnknown;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mrw_front.sv
`default_nettype none

module mrw_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         table_byte,
  input  wire logic               table_start,
  output logic                    push,
  output mrw_pkg::mrw_event_t     push_event
);
  import mrw_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_RECORDS = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] byte_offset, record_start, table_length, local_address;
  logic [7:0]  pending_type;

  phase_t      eff_phase;
  logic [31:0] o, eff_rs, eff_tl, eff_la;
  logic [7:0]  eff_pt;
  logic [31:0] tl_next, la_next, rs_next, remaining, b_wide;
  logic [7:0]  pt_next;
  logic        ev;
  mrw_event_t  e;

  // restart the walk on a start flag
  always_comb begin
    eff_phase = table_start ? PH_HEADER : phase;
    o         = table_start ? 32'd0 : byte_offset;
    eff_rs    = table_start ? 32'd0 : record_start;
    eff_tl    = table_start ? 32'd0 : table_length;
    eff_la    = table_start ? 32'd0 : local_address;
    eff_pt    = table_start ? 8'd0  : pending_type;
  end

  // classify the byte
  always_comb begin
    tl_next    = eff_tl;
    la_next    = eff_la;
    rs_next    = eff_rs;
    pt_next    = eff_pt;
    phase_next = eff_phase;
    b_wide     = {24'd0, table_byte};
    remaining  = eff_tl - eff_rs;
    ev         = 1'b0;
    e          = '0;
    case (eff_phase)
      PH_HEADER: begin
        if (o >= 32'd4 && o <= 32'd7) begin
          tl_next = eff_tl | (b_wide << {o[1:0], 3'b000});
        end else if (o >= 32'd36 && o <= 32'd39) begin
          la_next = eff_la | (b_wide << {o[1:0], 3'b000});
        end
        e.addr = la_next;
        if (o == 32'd7 && tl_next < 32'(HeaderBytes)) begin
          ev         = 1'b1;
          e.kind     = KindBad;
          e.cause    = CauseShort;
          phase_next = PH_IDLE;
        end else if (o == 32'(HeaderBytes - 1)) begin
          rs_next = 32'(HeaderBytes);
          if (tl_next == 32'(HeaderBytes)) begin
            ev         = 1'b1;
            e.kind     = KindGood;
            e.roff     = tl_next;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_RECORDS;
          end
        end
      end
      PH_RECORDS: begin
        e.addr = eff_la;
        e.roff = eff_rs;
        if (o == eff_rs) begin
          if (remaining < 32'd2) begin
            ev         = 1'b1;
            e.kind     = KindBad;
            e.cause    = CauseTruncated;
            phase_next = PH_IDLE;
          end else begin
            pt_next = table_byte;
          end
        end else if (o == eff_rs + 32'd1) begin
          ev      = 1'b1;
          e.rtype = eff_pt;
          e.rlen  = table_byte;
          if (table_byte < 8'd2) begin
            e.kind     = KindBad;
            e.cause    = CauseLenSmall;
            phase_next = PH_IDLE;
          end else if (b_wide > remaining) begin
            e.kind     = KindBad;
            e.cause    = CauseOverrun;
            phase_next = PH_IDLE;
          end else begin
            e.kind     = KindRecord;
            e.cls      = type_class(eff_pt);
            rs_next    = eff_rs + b_wide;
            if (b_wide == remaining) begin
              e.two_res  = 1'b1;
              e.good_off = eff_tl;
              phase_next = PH_IDLE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign push       = accept && ev;
  assign push_event = e;

  // advance the walk state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_offset   <= '0;
      record_start  <= '0;
      table_length  <= '0;
      local_address <= '0;
      pending_type  <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      record_start  <= rs_next;
      table_length  <= tl_next;
      local_address <= la_next;
      pending_type  <= pt_next;
      if (eff_phase != PH_IDLE) begin
        byte_offset <= o + 32'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mrw_queue.sv
`default_nettype none

module mrw_queue #(
  parameter int unsigned Depth = mrw_pkg::QueueDepthDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire mrw_pkg::mrw_event_t push_event,
  input  wire logic               pop,
  output mrw_pkg::mrw_event_t     head,
  output logic                    full,
  output logic                    empty
);
  import mrw_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mrw_event_t      mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_event;
    end
  end

  // move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
                                  count <= CntW'(Depth))
    else $error("queue occupancy out of range");

endmodule

`default_nettype wire

// File: hw/rtl/mrw_back.sv
`default_nettype none

module mrw_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mrw_pkg::mrw_event_t head,
  input  wire logic               empty,
  output logic                    pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [87:0]             m_tdata,
  output logic [1:0]              m_tuser,
  output logic                    m_tlast
);
  import mrw_pkg::*;

  logic        can_load;
  logic        sec_pending;
  logic [31:0] sec_off;
  logic [1:0]  kind;
  logic [7:0]  rtype, rlen;
  logic [31:0] roff, addr;
  logic [2:0]  cls;
  logic [1:0]  cause;
  logic        last;

  assign can_load = !m_tvalid || m_tready;
  assign pop      = can_load && !sec_pending && !empty;

  // hold control of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      sec_pending <= 1'b0;
    end else if (can_load) begin
      if (sec_pending) begin
        m_tvalid    <= 1'b1;
        sec_pending <= 1'b0;
      end else if (!empty) begin
        m_tvalid    <= 1'b1;
        sec_pending <= head.two_res;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // load the result payload; the verdict that follows a record reuses addr
  always_ff @(posedge clk) begin
    if (can_load) begin
      if (sec_pending) begin
        kind  <= KindGood;
        rtype <= '0;
        rlen  <= '0;
        roff  <= sec_off;
        cls   <= '0;
        cause <= '0;
        last  <= 1'b1;
      end else if (!empty) begin
        kind    <= head.kind;
        rtype   <= head.rtype;
        rlen    <= head.rlen;
        roff    <= head.roff;
        cls     <= head.cls;
        cause   <= head.cause;
        addr    <= head.addr;
        last    <= !head.two_res;
        sec_off <= head.good_off;
      end
    end
  end

  assign m_tdata = {3'b000, addr, cause, cls, roff, rlen, rtype};
  assign m_tuser = kind;
  assign m_tlast = last;

  a_second_held: assert property (@(posedge clk) disable iff (rst)
                                  sec_pending |-> m_tvalid && !m_tlast)
    else $error("pending verdict without a shown record");
  a_second_kind: assert property (@(posedge clk) disable iff (rst)
                                  sec_pending |-> m_tuser == KindRecord)
    else $error("pending verdict follows a non-record result");
  a_verdict_next: assert property (@(posedge clk) disable iff (rst)
                                   sec_pending && m_tready |=>
                                   m_tvalid && m_tlast && m_tuser == KindGood)
    else $error("verdict did not follow its record");

endmodule

`default_nettype wire

// File: hw/rtl/madt_record_walker_core.sv
// Channel | Signals                               | Beat
// s_*     | tvalid tready tdata[7:0] tuser[0]     | one table byte
// m_*     | tvalid tready tdata[87:0] tuser[1:0] tlast | one result
//
// Every byte is classified in the cycle it is accepted; a byte may be
// taken every cycle. Results leave one per cycle while m_tready is high,
// through the event queue and then an output register; the length byte
// of the last record gives two results, the record and its verdict.
// The event queue (QueueDepth entries) absorbs output stalls; s_tready
// drops only when it is full. Reset clears the walk to idle and empties
// the queue; bytes are ignored until one arrives with the start flag.
`default_nettype none

module madt_record_walker_core #(
  parameter int unsigned QueueDepth = mrw_pkg::QueueDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] table_byte
  input  wire logic        s_tuser,   // [0] table_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] record_type, [15:8] record_length, [47:16] record_offset,
  // [50:48] type_class, [52:51] error_cause, [84:53] controller_address,
  // [87:85] zero
  output logic [87:0]      m_tdata,
  output logic [1:0]       m_tuser,   // [1:0] result_kind
  output logic             m_tlast    // last_of_run
);
  import mrw_pkg::*;

  logic       accept, push, pop, full, empty;
  mrw_event_t push_event, head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  mrw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .table_byte (s_tdata),
    .table_start(s_tuser),
    .push       (push),
    .push_event (push_event)
  );

  mrw_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_event(push_event),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  mrw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

`default_nettype wire
